[rtl/gaus_pkg.sv]
// shared types and constants for the gaussian smoothing fir
// no dependencies
package gaus_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 17;
    localparam int NUM_WEIGHTS = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
    // up to 16 taps: four guard bits over a single product
    localparam int ACC_W       = PROD_W + 4;
    localparam int FRAC_SHIFT  = 16;
    localparam int ROUND_BIAS  = 32768;
    localparam int SAT_MAX     = 32767;
    localparam int SAT_MIN     = -32768;
    localparam int WEIGHT0_RST = 65536;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [WEIGHT_W-1:0] t_weight;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef struct packed {
        logic shift;  // a new sample enters the window
        logic adv;    // the pipeline moves one stage
    } t_cell_ctl;

endpackage

[rtl/gaus_in_if.sv]
// input sample channel: valid/ready handshake with one signed q4.12 sample
// depends on gaus_pkg
interface gaus_in_if;
    logic             valid;
    logic             ready;
    gaus_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[rtl/gaus_out_if.sv]
// smoothed sample channel: valid/ready handshake with one signed q4.12 sample
// depends on gaus_pkg
interface gaus_out_if;
    logic             valid;
    logic             ready;
    gaus_pkg::t_sample smoothed;

    modport source (output valid, output smoothed, input ready);
    modport sink   (input valid, input smoothed, output ready);
endinterface

[rtl/gaussian_smoothing_fir_top.sv]
// symmetric gaussian smoothing fir: a beat passes the tap sample register, the
// product register, the registered adder tree levels and the output register;
// one beat per cycle sustained while the sink takes results, the rate set by
// the shift of the tap cell chain; synchronous active-low reset clears the
// window to zero, weight_0 to 1.0 and all other weights to zero; depends on
// gaus_pkg, gaus_in_if, gaus_out_if, gaus_tap_cell, gaus_sum_tree
module gaussian_smoothing_fir_top #(
    parameter int LAG = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gaus_in_if.sink                            i_in,
    gaus_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [gaus_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gaus_pkg::WEIGHT_W-1:0]      i_cfg_data
);

    localparam int WIN  = 2 * LAG + 1;
    localparam int LVL  = (WIN > 1) ? $clog2(WIN) : 0;
    // window stage, product stage, then one stage per tree level
    localparam int NSTG = LVL + 2;
    localparam int ACC_W = gaus_pkg::ACC_W;

    // weight registers; the user must write them only while idle, the block does not enforce it
    gaus_pkg::t_weight r_weight [gaus_pkg::NUM_WEIGHTS];

    // pipeline control
    logic               w_adv;
    logic               w_accept;
    gaus_pkg::t_cell_ctl w_ctl;
    logic [NSTG-1:0]    r_vld;

    // cell chain wiring
    gaus_pkg::t_sample  w_samp [WIN];
    gaus_pkg::t_prod    w_prod [WIN];
    gaus_pkg::t_acc     w_sum;

    // output stage
    logic               r_out_vld;
    gaus_pkg::t_sample  r_out_data;
    gaus_pkg::t_sample  n_out_data;
    logic signed [ACC_W:0]                       w_biased;
    logic signed [ACC_W-gaus_pkg::FRAC_SHIFT:0] w_round;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gaus_pkg::NUM_WEIGHTS; k++) begin
                r_weight[k] <= (k == 0) ? gaus_pkg::WEIGHT_W'(gaus_pkg::WEIGHT0_RST) : '0;
            end
        end else if (i_cfg_we) begin
            r_weight[i_cfg_idx] <= i_cfg_data;
        end
    end

    // stages after the window move whenever the output register can take a beat
    assign w_adv     = !r_out_vld || o_out.ready;
    assign w_accept  = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    assign w_ctl.shift = w_accept;
    assign w_ctl.adv   = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], w_accept};
        end
    end

    // tap cells: cell 0 holds the oldest sample, the newest enters at the top
    generate
        for (genvar p = 0; p < WIN; p++) begin : g_cell
            localparam int OFF = (p < LAG) ? (LAG - p) : (p - LAG);
            gaus_pkg::t_sample w_in_samp;

            if (p == WIN - 1) begin : g_head
                assign w_in_samp = i_in.sample;
            end else begin : g_body
                assign w_in_samp = w_samp[p+1];
            end

            gaus_tap_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_sample (w_in_samp),
                .i_weight (r_weight[OFF]),
                .o_sample (w_samp[p]),
                .o_prod   (w_prod[p])
            );
        end
    endgenerate

    gaus_sum_tree #(
        .N (WIN)
    ) u_tree (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_prod (w_prod),
        .o_sum  (w_sum)
    );

    // round half up to q4.12, then clamp to the signed 16-bit range
    assign w_biased = {w_sum[ACC_W-1], w_sum} + (ACC_W+1)'(gaus_pkg::ROUND_BIAS);
    assign w_round  = w_biased[ACC_W:gaus_pkg::FRAC_SHIFT];

    always_comb begin
        if (w_round > (ACC_W-gaus_pkg::FRAC_SHIFT+1)'(gaus_pkg::SAT_MAX)) begin
            n_out_data = gaus_pkg::SAMPLE_W'(gaus_pkg::SAT_MAX);
        end else if (w_round < (ACC_W-gaus_pkg::FRAC_SHIFT+1)'(gaus_pkg::SAT_MIN)) begin
            n_out_data = gaus_pkg::SAMPLE_W'(gaus_pkg::SAT_MIN);
        end else begin
            n_out_data = w_round[gaus_pkg::SAMPLE_W-1:0];
        end
    end

    // output register parts the pipeline from the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.smoothed = r_out_data;

endmodule

[rtl/gaus_tap_cell.sv]
// one window cell: holds a sample, passes it to its older neighbor,
// and registers the product with its tap weight; depends on gaus_pkg
module gaus_tap_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gaus_pkg::t_cell_ctl i_ctl,
    input  gaus_pkg::t_sample   i_sample,
    input  gaus_pkg::t_weight   i_weight,
    output gaus_pkg::t_sample   o_sample,
    output gaus_pkg::t_prod     o_prod
);

    gaus_pkg::t_sample r_sample;
    gaus_pkg::t_prod   r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_sample;
        end
    end

    // weight is unsigned, so zero-extend it before the signed multiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= gaus_pkg::PROD_W'(r_sample * $signed({1'b0, i_weight}));
        end
    end

    assign o_sample = r_sample;
    assign o_prod   = r_prod;

endmodule

[rtl/gaus_sum_tree.sv]
// registered pairwise adder tree over the tap products
// depends on gaus_pkg
module gaus_sum_tree #(
    parameter int N = 15
) (
    input  logic            i_clk,
    input  logic            i_adv,
    input  gaus_pkg::t_prod i_prod [N],
    output gaus_pkg::t_acc  o_sum
);

    localparam int LVL  = (N > 1) ? $clog2(N) : 0;
    localparam int NPAD = 1 << LVL;
    localparam int NREG = (LVL > 0) ? LVL : 1;

    gaus_pkg::t_acc w_leaf [NPAD];
    gaus_pkg::t_acc r_node [NREG][NPAD];

    // pad to a power of two with zeros
    always_comb begin
        for (int i = 0; i < NPAD; i++) begin
            w_leaf[i] = (i < N) ? gaus_pkg::t_acc'(i_prod[i]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int l = 0; l < LVL; l++) begin
                for (int i = 0; i < NPAD / 2; i++) begin
                    if (i < (NPAD >> (l + 1))) begin
                        if (l == 0) begin
                            r_node[l][i] <= w_leaf[2*i] + w_leaf[2*i+1];
                        end else begin
                            r_node[l][i] <= r_node[l-1][2*i] + r_node[l-1][2*i+1];
                        end
                    end
                end
            end
        end
    end

    generate
        if (LVL == 0) begin : g_single
            assign o_sum = w_leaf[0];
        end else begin : g_tree
            assign o_sum = r_node[LVL-1][0];
        end
    endgenerate

endmodule

[tb/sv/tb_gaussian_smoothing_fir_top.sv]
`timescale 1ns / 100ps
// self-checking bench for the symmetric gaussian smoothing fir: random and directed
// samples against a bit-exact window predictor; depends on gaus_pkg, gaus_in_if, gaus_out_if
module tb_gaussian_smoothing_fir_top;

    localparam int LAG          = 7;
    localparam int WIN_LEN      = 2 * LAG + 1;
    localparam int LATENCY      = 2 + $clog2(WIN_LEN);
    localparam int RESET_CYCLES = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_AFTER   = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_PRINTS   = 30;

    typedef logic [gaus_pkg::CFG_IDX_W-1:0] t_cfg_idx;

    // weight_k sits at index k, starting from the centre tap
    localparam t_cfg_idx REG_WEIGHT_0 = t_cfg_idx'(0);

    localparam gaus_pkg::t_weight WEIGHT_MAX = '1;

    // sigma = 2 gaussian, normalized so the two-sided sum is close to 1.0
    localparam gaus_pkg::t_weight GAUSS_SIGMA2 [gaus_pkg::NUM_WEIGHTS] = '{
        17'd13075, 17'd11539, 17'd7930, 17'd4245, 17'd1769, 17'd574, 17'd145, 17'd29
    };

    // kinds of weight set used by the random phases
    typedef enum int {
        WSET_GAUSS,
        WSET_UNITY_RANGE,
        WSET_FULL_RANGE,
        WSET_ALL_MAX,
        WSET_ALL_ZERO,
        WSET_SMALL_GAIN,
        WSET_IDENTITY,
        WSET_SPARSE
    } t_wset;

    // keeps its own copy of the window and weights and predicts each smoothed beat
    class smoothing_scoreboard;
        gaus_pkg::t_weight weights [gaus_pkg::NUM_WEIGHTS];
        gaus_pkg::t_sample window [WIN_LEN];
        gaus_pkg::t_sample pending_smoothed [$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            foreach (weights[k]) weights[k] = '0;
            weights[0] = gaus_pkg::t_weight'(gaus_pkg::WEIGHT0_RST);
            foreach (window[p]) window[p] = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_weight(int unsigned k, gaus_pkg::t_weight w);
            weights[k] = w;
        endfunction

        // shift in the new sample, weighted sum, round half up, saturate
        function gaus_pkg::t_sample smooth_sample(gaus_pkg::t_sample s);
            longint acc;
            longint q;
            int     p;
            int     off;
            for (p = 0; p < WIN_LEN - 1; p++) window[p] = window[p + 1];
            window[WIN_LEN - 1] = s;
            acc = 0;
            for (p = 0; p < WIN_LEN; p++) begin
                off = (p >= LAG) ? p - LAG : LAG - p;
                if (off < gaus_pkg::NUM_WEIGHTS)
                    acc += longint'(window[p]) * longint'(weights[off]);
            end
            q = (acc + gaus_pkg::ROUND_BIAS) >>> gaus_pkg::FRAC_SHIFT;
            if (q > gaus_pkg::SAT_MAX) q = gaus_pkg::SAT_MAX;
            if (q < gaus_pkg::SAT_MIN) q = gaus_pkg::SAT_MIN;
            return gaus_pkg::t_sample'(q);
        endfunction

        function void note_sample(gaus_pkg::t_sample s);
            pending_smoothed.push_back(smooth_sample(s));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_smoothed(gaus_pkg::t_sample got);
            gaus_pkg::t_sample want;
            checked++;
            if (pending_smoothed.size() == 0) begin
                report_mismatch($sformatf("smoothed %0d arrived with no sample pending", got));
            end else begin
                want = pending_smoothed.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("beat %0d: smoothed %0d, expected %0d",
                                              checked, got, want));
            end
        endtask
    endclass

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_idx;
    gaus_pkg::t_weight i_cfg_data;

    gaus_in_if  in_ch ();
    gaus_out_if out_ch ();

    smoothing_scoreboard sb;
    int unsigned         cycle_cnt = 0;
    bit                  hold_done = 1'b0;

    gaussian_smoothing_fir_top #(
        .LAG(LAG)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly back to back, often a short gap, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sample mix: mostly within +-1.0, some full range, extremes and tiny values
    function automatic gaus_pkg::t_sample random_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return gaus_pkg::t_sample'($signed($urandom_range(0, 8191)) - 4096);
        if (r < 80) return gaus_pkg::t_sample'($urandom);
        if (r < 90) return ($urandom_range(0, 1) != 0) ? gaus_pkg::t_sample'(gaus_pkg::SAT_MAX)
                                                       : gaus_pkg::t_sample'(gaus_pkg::SAT_MIN);
        return gaus_pkg::t_sample'($signed($urandom_range(0, 16)) - 8);
    endfunction

    // one input beat: optional idle gap, then hold valid until ready is seen at a rising edge
    task automatic send_sample(gaus_pkg::t_sample s, int unsigned gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // sender stops until every expected beat has come back
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_smoothed.size() != 0) @(negedge i_clk);
    endtask

    // idle point for register writes: drained plus the pipeline depth
    task automatic settle_idle();
        drain_results();
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_weight(int unsigned k, gaus_pkg::t_weight w);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WEIGHT_0 + t_cfg_idx'(k);
        i_cfg_data <= w;
        sb.set_weight(k, w);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_weight_set(t_wset kind);
        gaus_pkg::t_weight w;
        int unsigned       k;
        for (k = 0; k < gaus_pkg::NUM_WEIGHTS; k++) begin
            case (kind)
                WSET_GAUSS:       w = GAUSS_SIGMA2[k];
                WSET_UNITY_RANGE: w = gaus_pkg::t_weight'($urandom_range(0,
                                          gaus_pkg::WEIGHT0_RST));
                WSET_FULL_RANGE:  w = gaus_pkg::t_weight'($urandom_range(0, int'(WEIGHT_MAX)));
                WSET_ALL_MAX:     w = WEIGHT_MAX;
                WSET_ALL_ZERO:    w = '0;
                WSET_SMALL_GAIN:  w = gaus_pkg::t_weight'($urandom_range(0,
                                          gaus_pkg::WEIGHT0_RST / WIN_LEN));
                WSET_IDENTITY:    w = (k == 0) ? gaus_pkg::t_weight'(gaus_pkg::WEIGHT0_RST)
                                               : '0;
                default: begin
                    // sparse: about half the taps switched off
                    w = ($urandom_range(0, 1) != 0) ? '0
                        : gaus_pkg::t_weight'($urandom_range(0, int'(WEIGHT_MAX)));
                end
            endcase
            write_weight(k, w);
        end
    endtask

    // accepted beats on both channels go to the scoreboard, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample);
            if (out_ch.valid && out_ch.ready) sb.check_smoothed(out_ch.smoothed);
        end
    end

    // result side: random ready pattern, long open stretches, and one long hold-off
    initial begin : sink_side
        int unsigned run;
        int unsigned stall;
        int unsigned c;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && sb != null && sb.checked >= HOLD_AFTER) begin
                // hold-off long enough to back the pipeline up into the input
                hold_done = 1'b1;
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                for (c = 1; c < HOLD_CYCLES; c++) @(negedge i_clk);
            end
            run   = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
            stall = pick_gap();
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            if (stall > 0) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("gaussian_smoothing_fir_top verification failed");
        $finish;
    end

    initial begin : stimulus
        gaus_pkg::t_sample ramp_hi [5];
        gaus_pkg::t_sample half_step [4];
        int                ph;
        int                n;
        bit                burst;
        int unsigned       gap;

        sb = new();
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset weights give a pass-through: field extremes and the values around zero
        ramp_hi = '{gaus_pkg::t_sample'(gaus_pkg::SAT_MAX), gaus_pkg::t_sample'(gaus_pkg::SAT_MIN),
                    gaus_pkg::t_sample'(0), gaus_pkg::t_sample'(1), gaus_pkg::t_sample'(-1)};
        foreach (ramp_hi[i]) send_sample(ramp_hi[i], 0);
        settle_idle();

        // centre weight of one half: odd samples land exactly on the rounding midpoint
        load_weight_set(WSET_ALL_ZERO);
        write_weight(0, gaus_pkg::t_weight'(gaus_pkg::WEIGHT0_RST / 2));
        half_step = '{gaus_pkg::t_sample'(1), gaus_pkg::t_sample'(-1),
                      gaus_pkg::t_sample'(3), gaus_pkg::t_sample'(-3)};
        foreach (half_step[i]) send_sample(half_step[i], 0);
        settle_idle();

        // every weight above 1.0: drive into both saturation limits
        load_weight_set(WSET_ALL_MAX);
        repeat (8) send_sample(gaus_pkg::t_sample'(gaus_pkg::SAT_MAX), 0);
        repeat (8) send_sample(gaus_pkg::t_sample'(gaus_pkg::SAT_MIN), 0);
        settle_idle();

        // random phases, one weight set each; the window carries over between phases
        for (ph = 0; ph < PHASES; ph++) begin
            load_weight_set(t_wset'(ph));
            burst = (ph % 3 == 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // one pause of the sender until everything is back
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
                gap = burst ? 0 : pick_gap();
                send_sample(random_sample(), gap);
            end
            settle_idle();
        end

        while (sb.pending_smoothed.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("gaussian_smoothing_fir_top verification clean");
        end else begin
            $display("gaussian_smoothing_fir_top verification failed");
        end
        $finish;
    end

endmodule
